### rtl/hsl_pkg.sv
// Shared types and constants for the RGB to HSL pixel converter.
package hsl_pkg;

    localparam int DIV_W     = 11;            // remainder/divisor width, 6*C fits in 11 bits
    localparam int QUO_W     = 18;            // quotient shift register width
    localparam int NUM_CELLS = 17;            // one quotient bit per cell
    localparam int LATENCY   = NUM_CELLS + 2; // prep stage + cells + output stage

    localparam logic [8:0] HALF_SUM = 9'd255;
    localparam logic [8:0] FULL_SUM = 9'd510;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [15:0] hue_turn;
        logic [15:0] saturation_q15;
        logic [8:0]  lightness_sum;
    } result_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic       vld;
        logic       grey;
        logic [8:0] sum;
        lane_t      hue;
        lane_t      sat;
    } stage_t;

endpackage

### rtl/rgb_to_hsl_pixel.sv
// RGB to HSL pixel converter, top level.
// Accepts one pixel on every clock cycle in which start is high; busy never rises.
// Each pixel's result appears on result with a one-cycle done strobe, in order,
// after one prep stage, a row of 17 division cells (one quotient bit of hue and
// of saturation per cell), and one rounding stage. The receiver cannot stall,
// so results must be taken as they appear. Throughput is one pixel per clock.
module rgb_to_hsl_pixel
    import hsl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  pixel_t  pixel,
    output logic    done,
    output result_t result
);

    stage_t chain [0:NUM_CELLS];

    assign busy = 1'b0;

    hsl_prep u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .pixel (pixel),
        .dout  (chain[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        hsl_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    hsl_round u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (chain[NUM_CELLS]),
        .done   (done),
        .result (result)
    );

endmodule

### rtl/hsl_prep.sv
// Front stage: max/min, chroma, hue position and saturation divisor.
module hsl_prep
    import hsl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  pixel_t pixel,
    output stage_t dout
);

    logic [7:0]       hi;
    logic [7:0]       lo;
    logic [7:0]       chroma;
    logic [8:0]       sum;
    logic [8:0]       limit;
    logic [DIV_W-1:0] r11;
    logic [DIV_W-1:0] g11;
    logic [DIV_W-1:0] b11;
    logic [DIV_W-1:0] c11;
    logic [DIV_W-1:0] den6;
    logic [DIV_W-1:0] pos;
    logic             sat_int;
    logic             vld_reg;
    stage_t           data_reg;
    stage_t           data_next;

    always_comb
    begin
        hi = (pixel.red_in > pixel.green_in) ? pixel.red_in : pixel.green_in;
        hi = (hi > pixel.blue_in) ? hi : pixel.blue_in;
        lo = (pixel.red_in < pixel.green_in) ? pixel.red_in : pixel.green_in;
        lo = (lo < pixel.blue_in) ? lo : pixel.blue_in;
        chroma = hi - lo;
        sum = {1'b0, hi} + {1'b0, lo};
        r11 = DIV_W'(pixel.red_in);
        g11 = DIV_W'(pixel.green_in);
        b11 = DIV_W'(pixel.blue_in);
        c11 = DIV_W'(chroma);
        den6 = (c11 << 2) + (c11 << 1);

        // ties: red sector wins, then green
        priority if (hi == pixel.red_in)
        begin
            if (pixel.green_in >= pixel.blue_in)
                pos = g11 - b11;
            else
                pos = den6 - (b11 - g11);
        end
        else if (hi == pixel.green_in)
            pos = (c11 << 1) + b11 - r11;
        else
            pos = (c11 << 2) + r11 - g11;

        limit = (sum <= HALF_SUM) ? sum : (FULL_SUM - sum);
        // C equals divisor only at S = 1 or black/white: integer bit set up front
        sat_int = ({1'b0, chroma} >= limit);

        data_next.vld     = 1'b1;
        data_next.grey    = (chroma == 8'd0);
        data_next.sum     = sum;
        data_next.hue.rem = pos;
        data_next.hue.den = den6;
        data_next.hue.quo = '0;
        data_next.sat.rem = sat_int ? '0 : c11;
        data_next.sat.den = DIV_W'(limit);
        data_next.sat.quo = QUO_W'(sat_int);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            data_reg <= data_next;
    end

    always_comb
    begin
        dout     = data_reg;
        dout.vld = vld_reg;
    end

endmodule

### rtl/hsl_div_cell.sv
// One restoring-division cell: one quotient bit for the hue and saturation lanes.
module hsl_div_cell
    import hsl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  stage_t din,
    output stage_t dout
);

    logic   vld_reg;
    stage_t data_reg;
    stage_t data_next;

    function automatic lane_t div_step(lane_t l);
        logic [DIV_W:0] t;
        logic           ge;
        lane_t          o;
        t  = {l.rem, 1'b0};
        ge = (t >= {1'b0, l.den});
        o.den = l.den;
        o.rem = ge ? DIV_W'(t - {1'b0, l.den}) : DIV_W'(t);
        o.quo = {l.quo[QUO_W-2:0], ge};
        return o;
    endfunction

    always_comb
    begin
        data_next     = din;
        data_next.hue = div_step(din.hue);
        data_next.sat = div_step(din.sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= din.vld;
    end

    always_ff @(posedge clk)
    begin
        if (din.vld)
            data_reg <= data_next;
    end

    always_comb
    begin
        dout     = data_reg;
        dout.vld = vld_reg;
    end

endmodule

### rtl/hsl_round.sv
// Output stage: round both quotients to nearest (zero for grey pixels) and register the result beat.
module hsl_round
    import hsl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  stage_t  din,
    output logic    done,
    output result_t result
);

    logic [17:0] hue_sum;
    logic [17:0] sat_sum;
    logic        done_reg;
    result_t     result_reg;
    result_t     result_next;

    always_comb
    begin
        // hue has one extra fraction bit, saturation two (lowest cut); add one and drop it to round
        hue_sum = {1'b0, din.hue.quo[16:0]} + 18'd1;
        sat_sum = {1'b0, din.sat.quo[QUO_W-1:1]} + 18'd1;
        result_next.lightness_sum = din.sum;
        if (din.grey)
        begin
            result_next.hue_turn       = '0;
            result_next.saturation_q15 = '0;
        end
        else
        begin
            result_next.hue_turn       = hue_sum[16:1];
            result_next.saturation_q15 = sat_sum[16:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= din.vld;
    end

    always_ff @(posedge clk)
    begin
        if (din.vld)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/hsl_checker.sv
// Port-level checks for the RGB to HSL converter, bound to the top level.
module hsl_checker
    import hsl_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input pixel_t  pixel,
    input logic    done,
    input result_t result
);

    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted beat produced no result");

    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without matching input beat");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.saturation_q15 <= 16'd32768))
        else $error("saturation above 1.0");

    a_black_white: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.lightness_sum == 9'd0 || result.lightness_sum == 9'd510))
        |-> (result.hue_turn == 16'd0 && result.saturation_q15 == 16'd0))
        else $error("black or white pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsl_pixel hsl_checker u_hsl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result)
);
